[rtl/quat_to_euler_linear_accel_macros.svh]
// Assertion macros shared by the quaternion to Euler angle block.
// Taken in by `include in the files that carry assertions; no other dependency.
`ifndef QUAT_TO_EULER_LINEAR_ACCEL_MACROS_SVH
`define QUAT_TO_EULER_LINEAR_ACCEL_MACROS_SVH

// property that must hold at every clock edge out of reset
`define QTEL_ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define QTEL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/qtel_pkg.sv]
// Types and constants for the quaternion to Euler angle block.
// No dependencies; used by the cells and the top level.
`default_nettype none

package qtel_pkg;

   localparam int ATAN_ENTRIES = 24;
   localparam int SQRT_DIGITS  = 29;      // root bits of the pitch cosine
   localparam int ROOT_W       = 29;
   localparam int REM_W        = 31;
   localparam int RAD_W        = 58;      // radicand, two bits per digit
   localparam int XY_W         = 38;      // CORDIC vector width
   localparam int Z_W          = 34;      // CORDIC angle width, binary angle units
   localparam int SUM_W        = 36;      // quaternion product sums, Q.28
   localparam int S_W          = 30;      // clamped asin argument
   localparam int GPROD_W      = 47;      // |gravity component| * magnitude

   localparam logic [31:0] ATAN_BAM [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam logic signed [SUM_W-1:0] ONE_Q28     = 36'sd268435456;
   localparam logic signed [Z_W-1:0]   BAM_HALF    = 34'sd2147483648;
   localparam logic signed [Z_W-1:0]   BAM_QUARTER = 34'sd1073741824;
   localparam logic [31:0]             PI_Q30      = 32'd3373259426;
   localparam logic signed [15:0]      ROLL_LIM    = 16'sd12868;
   localparam logic signed [15:0]      PITCH_LIM   = 16'sd6434;

   // register map
   localparam logic [0:0]  REG_GRAVITY   = 1'b0;
   localparam logic [10:0] GRAVITY_RESET = 11'd979;

   // angle lanes
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   typedef struct packed {
      logic signed [SUM_W-1:0] rx;
      logic signed [SUM_W-1:0] ry;
      logic signed [SUM_W-1:0] yx;
      logic signed [SUM_W-1:0] yy;
      logic signed [S_W-1:0]   s;
      logic [2:0][15:0]        lin;
   } line_type;

   typedef struct packed {
      logic [2:0]       zero;   // first operand of atan2 was zero
      logic [2:0]       half;   // second operand of atan2 was negative
      logic [2:0][15:0] lin;
   } cside_type;

endpackage

`default_nettype wire

[rtl/qtel_sqrt_cell.sv]
// One digit of the pipelined integer square root (restoring, two radicand bits).
// Depends on qtel_pkg.
`default_nettype none

module qtel_sqrt_cell (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [qtel_pkg::REM_W-1:0]    rem_i,
   input  wire logic [qtel_pkg::ROOT_W-1:0]   root_i,
   input  wire logic [qtel_pkg::RAD_W-1:0]    rad_i,
   output logic      [qtel_pkg::REM_W-1:0]    rem_o,
   output logic      [qtel_pkg::ROOT_W-1:0]   root_o,
   output logic      [qtel_pkg::RAD_W-1:0]    rad_o
);

   logic [qtel_pkg::REM_W+1:0] rem2;
   logic [qtel_pkg::REM_W+1:0] trial;
   logic [qtel_pkg::REM_W-1:0] rem_in,  rem_ff;
   logic [qtel_pkg::ROOT_W-1:0] root_in, root_ff;
   logic [qtel_pkg::RAD_W-1:0] rad_in,  rad_ff;

   // bring down two bits, try subtracting 4*root+1
   always_comb begin
      rem2  = {rem_i, rad_i[qtel_pkg::RAD_W-1 -: 2]};
      trial = (qtel_pkg::REM_W+2)'({root_i, 2'b01});
      if (rem2 >= trial) begin
         rem_in  = qtel_pkg::REM_W'(rem2 - trial);
         root_in = {root_i[qtel_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = qtel_pkg::REM_W'(rem2);
         root_in = {root_i[qtel_pkg::ROOT_W-2:0], 1'b0};
      end
      rad_in = {rad_i[qtel_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign rad_o  = rad_ff;

endmodule

`default_nettype wire

[rtl/qtel_cordic_cell.sv]
// One vectoring CORDIC iteration with its output register.
// Depends on qtel_pkg.
`default_nettype none

module qtel_cordic_cell #(
   parameter int          SHIFT = 0,
   parameter logic [31:0] ATAN  = 32'd0
) (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [qtel_pkg::XY_W-1:0]   x_i,
   input  wire logic signed [qtel_pkg::XY_W-1:0]   y_i,
   input  wire logic signed [qtel_pkg::Z_W-1:0]    z_i,
   output logic      signed [qtel_pkg::XY_W-1:0]   x_o,
   output logic      signed [qtel_pkg::XY_W-1:0]   y_o,
   output logic      signed [qtel_pkg::Z_W-1:0]    z_o
);

   logic signed [qtel_pkg::XY_W-1:0] xs, ys;
   logic signed [qtel_pkg::Z_W-1:0]  step;
   logic signed [qtel_pkg::XY_W-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [qtel_pkg::Z_W-1:0]  z_in, z_ff;

   // rotate toward the x axis
   always_comb begin
      xs   = x_i >>> SHIFT;
      ys   = y_i >>> SHIFT;
      step = $signed(qtel_pkg::Z_W'(ATAN));
      if (!y_i[qtel_pkg::XY_W-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + step;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

`default_nettype wire

[rtl/quat_to_euler_linear_accel.sv]
// Quaternion to ZYX Euler angles with gravity removal, fully pipelined.
// Depends on qtel_pkg, qtel_sqrt_cell, qtel_cordic_cell and the macros header.
//
//   channel   ports          transfer when             content
//   input     req_*          req_valid & req_ready     quaternion Q2.14, accel
//   output    rsp_*          rsp_valid & rsp_ready     roll/yaw Q3.12, pitch Q2.12, linear
//   config    psel..pready   psel&penable&pwrite       gravity_magnitude at 0x0
//
// One item per cycle while the output is not stalled. The pipeline holds the
// product, sum and square stages, 29 square root digit cells, the
// min(CORDIC_STAGES,24) CORDIC cells and three stages of angle scaling. A stalled
// output freezes the whole chain, so req_ready = !rsp_valid | rsp_ready. Reset
// clears the valid bits and sets gravity_magnitude to 979.
`default_nettype none
`include "quat_to_euler_linear_accel_macros.svh"

module quat_to_euler_linear_accel #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [14:0]      rsp_roll_angle,
   output logic signed [13:0]      rsp_pitch_angle,
   output logic signed [14:0]      rsp_yaw_angle,
   output logic signed [15:0]      rsp_linear_x,
   output logic signed [15:0]      rsp_linear_y,
   output logic signed [15:0]      rsp_linear_z,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int NC  = (CORDIC_STAGES < qtel_pkg::ATAN_ENTRIES) ?
                        CORDIC_STAGES : qtel_pkg::ATAN_ENTRIES;
   localparam int SQD = qtel_pkg::SQRT_DIGITS;
   localparam int TOT = 3 + SQD + NC + 3;
   localparam int SW  = qtel_pkg::SUM_W;
   localparam int XW  = qtel_pkg::XY_W;
   localparam int ZW  = qtel_pkg::Z_W;

   logic stage_en;
   logic [TOT-1:0] valid_in, valid_ff;
   logic [10:0] gravity_in, gravity_ff;

   // ---------------------------------------------------------------
   // control: one enable for the whole chain
   assign stage_en  = !valid_ff[TOT-1] || rsp_ready;
   assign req_ready = stage_en;
   assign rsp_valid = valid_ff[TOT-1];

   always_comb begin
      valid_in   = stage_en ? {valid_ff[TOT-2:0], req_valid} : valid_ff;
      gravity_in = gravity_ff;
      if (psel && penable && pwrite && paddr[2] == qtel_pkg::REG_GRAVITY) begin
         gravity_in = pwdata[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         gravity_ff <= qtel_pkg::GRAVITY_RESET;
      end else begin
         valid_ff   <= valid_in;
         gravity_ff <= gravity_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == qtel_pkg::REG_GRAVITY) ? {21'd0, gravity_ff} : 32'd0;

   // ---------------------------------------------------------------
   // stage 1: quaternion products
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, ww_ff, zz_ff;
   logic [2:0][15:0] acc1_ff;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         wx_ff   <= req_quat_w * req_quat_x;
         yz_ff   <= req_quat_y * req_quat_z;
         xx_ff   <= req_quat_x * req_quat_x;
         yy_ff   <= req_quat_y * req_quat_y;
         wy_ff   <= req_quat_w * req_quat_y;
         zx_ff   <= req_quat_z * req_quat_x;
         wz_ff   <= req_quat_w * req_quat_z;
         xy_ff   <= req_quat_x * req_quat_y;
         ww_ff   <= req_quat_w * req_quat_w;
         zz_ff   <= req_quat_z * req_quat_z;
         acc1_ff <= {req_accel_z, req_accel_y, req_accel_x};
      end
   end

   // ---------------------------------------------------------------
   // stage 2: rotation matrix terms, asin argument clamp
   logic signed [SW-1:0] rx_in, ry_in, yx_in, yy_in, gx_in, gz_in, sraw;
   logic signed [qtel_pkg::S_W-1:0] s_in;
   logic signed [SW-1:0] rx_ff, ry_ff, yx_ff, yy2_ff, gx_ff, gz_ff;
   logic signed [qtel_pkg::S_W-1:0] s_ff;
   logic [2:0][15:0] acc2_ff;

   always_comb begin
      ry_in = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      rx_in = qtel_pkg::ONE_Q28 - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
      yy_in = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
      yx_in = qtel_pkg::ONE_Q28 - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      sraw  = (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
      gx_in = (SW'(zx_ff) - SW'(wy_ff)) <<< 1;
      gz_in = SW'(ww_ff) - SW'(xx_ff) - SW'(yy_ff) + SW'(zz_ff);
      if (sraw > qtel_pkg::ONE_Q28) begin
         s_in = qtel_pkg::S_W'(qtel_pkg::ONE_Q28);
      end else if (sraw < -qtel_pkg::ONE_Q28) begin
         s_in = qtel_pkg::S_W'(-qtel_pkg::ONE_Q28);
      end else begin
         s_in = qtel_pkg::S_W'(sraw);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         yx_ff   <= yx_in;
         yy2_ff  <= yy_in;
         gx_ff   <= gx_in;
         gz_ff   <= gz_in;
         s_ff    <= s_in;
         acc2_ff <= acc1_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: radicand 1 - s^2 and gravity magnitude products
   logic signed [59:0] ssq;
   logic [qtel_pkg::RAD_W-1:0] rad_in, rad_ff;
   logic [2:0][SW-1:0] gcomp;
   logic [2:0][SW-1:0] gabs;
   logic [2:0] gneg_in, gneg_ff;
   logic [2:0][qtel_pkg::GPROD_W-1:0] gprod_in, gprod_ff;
   logic signed [SW-1:0] rx3_ff, ry3_ff, yx3_ff, yy3_ff;
   logic signed [qtel_pkg::S_W-1:0] s3_ff;
   logic [2:0][15:0] acc3_ff;

   always_comb begin
      ssq    = s_ff * s_ff;
      rad_in = qtel_pkg::RAD_W'((60'sd1 <<< 56) - ssq);
      gcomp  = {gz_ff, ry_ff, gx_ff};
      for (int i = 0; i < 3; i++) begin
         gneg_in[i]  = gcomp[i][SW-1];
         gabs[i]     = gneg_in[i] ? (~gcomp[i] + 1'b1) : gcomp[i];
         gprod_in[i] = qtel_pkg::GPROD_W'(gabs[i]) * qtel_pkg::GPROD_W'(gravity_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rad_ff   <= rad_in;
         gneg_ff  <= gneg_in;
         gprod_ff <= gprod_in;
         rx3_ff   <= rx_ff;
         ry3_ff   <= ry_ff;
         yx3_ff   <= yx_ff;
         yy3_ff   <= yy2_ff;
         s3_ff    <= s_ff;
         acc3_ff  <= acc2_ff;
      end
   end

   // ---------------------------------------------------------------
   // square root cells with the side line that rides alongside
   logic [qtel_pkg::REM_W-1:0]  sq_rem  [SQD+1];
   logic [qtel_pkg::ROOT_W-1:0] sq_root [SQD+1];
   logic [qtel_pkg::RAD_W-1:0]  sq_rad  [SQD+1];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad_ff;

   for (genvar k = 0; k < SQD; k++) begin : g_sqrt
      qtel_sqrt_cell u_cell (
         .clock  (clock),
         .en     (stage_en),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .rad_i  (sq_rad[k]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1]),
         .rad_o  (sq_rad[k+1])
      );
   end

   // gravity rounding, subtract and saturate enter the side line
   localparam int GPROD_W_L = qtel_pkg::GPROD_W + 1;
   logic [2:0][GPROD_W_L-1:0] grnd;
   logic signed [20:0] gsub, gdiff;
   qtel_pkg::line_type line_in;
   qtel_pkg::line_type line_ff [SQD];

   always_comb begin
      line_in.rx = rx3_ff;
      line_in.ry = ry3_ff;
      line_in.yx = yx3_ff;
      line_in.yy = yy3_ff;
      line_in.s  = s3_ff;
      for (int i = 0; i < 3; i++) begin
         grnd[i] = GPROD_W_L'(gprod_ff[i]) + (GPROD_W_L'(1) << 27);
         gsub    = $signed({1'b0, grnd[i][GPROD_W_L-1:28]});
         gsub    = gneg_ff[i] ? -gsub : gsub;
         gdiff   = 21'($signed(acc3_ff[i])) - gsub;
         if (gdiff > 21'sd32767) begin
            line_in.lin[i] = 16'h7fff;
         end else if (gdiff < -21'sd32768) begin
            line_in.lin[i] = 16'h8000;
         end else begin
            line_in.lin[i] = gdiff[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         line_ff[0] <= line_in;
         for (int k = 1; k < SQD; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // pre-rotation into the right half plane, then the CORDIC cells
   logic signed [XW-1:0] cx [3][NC+1];
   logic signed [XW-1:0] cy [3][NC+1];
   logic signed [ZW-1:0] cz [3][NC+1];
   logic signed [XW-1:0] px [3];
   logic signed [XW-1:0] py [3];
   qtel_pkg::cside_type cside_in;
   qtel_pkg::cside_type cside_ff [NC];

   always_comb begin
      py[qtel_pkg::LANE_ROLL]  = XW'(line_ff[SQD-1].ry);
      px[qtel_pkg::LANE_ROLL]  = XW'(line_ff[SQD-1].rx);
      py[qtel_pkg::LANE_PITCH] = XW'(line_ff[SQD-1].s);
      px[qtel_pkg::LANE_PITCH] = $signed(XW'(sq_root[SQD]));
      py[qtel_pkg::LANE_YAW]   = XW'(line_ff[SQD-1].yy);
      px[qtel_pkg::LANE_YAW]   = XW'(line_ff[SQD-1].yx);
      cside_in.lin = line_ff[SQD-1].lin;
      for (int l = 0; l < 3; l++) begin
         cside_in.zero[l] = (py[l] == '0);
         cside_in.half[l] = px[l][XW-1];
         if (px[l][XW-1] && !py[l][XW-1]) begin
            cx[l][0] = py[l];
            cy[l][0] = -px[l];
            cz[l][0] = qtel_pkg::BAM_QUARTER;
         end else if (px[l][XW-1]) begin
            cx[l][0] = -py[l];
            cy[l][0] = px[l];
            cz[l][0] = -qtel_pkg::BAM_QUARTER;
         end else begin
            cx[l][0] = px[l];
            cy[l][0] = py[l];
            cz[l][0] = '0;
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      for (genvar k = 0; k < NC; k++) begin : g_iter
         qtel_cordic_cell #(
            .SHIFT (k),
            .ATAN  (qtel_pkg::ATAN_BAM[k])
         ) u_cell (
            .clock (clock),
            .en    (stage_en),
            .x_i   (cx[l][k]),
            .y_i   (cy[l][k]),
            .z_i   (cz[l][k]),
            .x_o   (cx[l][k+1]),
            .y_o   (cy[l][k+1]),
            .z_o   (cz[l][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         cside_ff[0] <= cside_in;
         for (int k = 1; k < NC; k++) begin
            cside_ff[k] <= cside_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // angle stage A: zero-vector override, clamp to a half turn, magnitude
   logic signed [ZW-1:0] zsel [3];
   logic [2:0] asign_in, asign_ff, psign_ff;
   logic [2:0][31:0] amag_in, amag_ff;
   logic [2:0][15:0] lin_a_ff, lin_b_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (cside_ff[NC-1].zero[l]) begin
            zsel[l] = cside_ff[NC-1].half[l] ? qtel_pkg::BAM_HALF : '0;
         end else begin
            zsel[l] = cz[l][NC];
         end
         if (zsel[l] > qtel_pkg::BAM_HALF) begin
            zsel[l] = qtel_pkg::BAM_HALF;
         end else if (zsel[l] < -qtel_pkg::BAM_HALF) begin
            zsel[l] = -qtel_pkg::BAM_HALF;
         end
         asign_in[l] = zsel[l][ZW-1];
         amag_in[l]  = asign_in[l] ? 32'(-zsel[l]) : 32'(zsel[l]);
      end
   end

   // angle stage B: scale by pi
   logic [2:0][63:0] aprod_ff;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         asign_ff <= asign_in;
         amag_ff  <= amag_in;
         lin_a_ff <= cside_ff[NC-1].lin;
         psign_ff <= asign_ff;
         lin_b_ff <= lin_a_ff;
         for (int l = 0; l < 3; l++) begin
            aprod_ff[l] <= 64'(amag_ff[l]) * 64'(qtel_pkg::PI_Q30);
         end
      end
   end

   // angle stage C: round half away from zero, clamp, output register
   logic [64:0] around [3];
   logic signed [15:0] aval [3];
   logic signed [15:0] lim  [3];
   logic signed [15:0] aout [3];
   logic signed [14:0] roll_in, roll_ff, yaw_in, yaw_ff;
   logic signed [13:0] pitch_in, pitch_ff;
   logic [2:0][15:0] lin_out_ff;

   always_comb begin
      lim[qtel_pkg::LANE_ROLL]  = qtel_pkg::ROLL_LIM;
      lim[qtel_pkg::LANE_PITCH] = qtel_pkg::PITCH_LIM;
      lim[qtel_pkg::LANE_YAW]   = qtel_pkg::ROLL_LIM;
      for (int l = 0; l < 3; l++) begin
         around[l] = {1'b0, aprod_ff[l]} + (65'd1 << 48);
         aval[l]   = $signed({1'b0, around[l][63:49]});
         aval[l]   = psign_ff[l] ? -aval[l] : aval[l];
         if (aval[l] > lim[l]) begin
            aout[l] = lim[l];
         end else if (aval[l] < -lim[l]) begin
            aout[l] = -lim[l];
         end else begin
            aout[l] = aval[l];
         end
      end
      roll_in  = aout[qtel_pkg::LANE_ROLL][14:0];
      pitch_in = aout[qtel_pkg::LANE_PITCH][13:0];
      yaw_in   = aout[qtel_pkg::LANE_YAW][14:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         roll_ff    <= roll_in;
         pitch_ff   <= pitch_in;
         yaw_ff     <= yaw_in;
         lin_out_ff <= lin_b_ff;
      end
   end

   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_linear_x    = lin_out_ff[0];
   assign rsp_linear_y    = lin_out_ff[1];
   assign rsp_linear_z    = lin_out_ff[2];

   // ---------------------------------------------------------------
   // checks
   `QTEL_ASSERT_HOLDS(a_ready_tracks_out, clock, reset, req_ready == (!rsp_valid || rsp_ready), "input ready does not follow output stall")
   `QTEL_ASSERT_NEXT(a_stall_freezes, clock, reset, !stage_en, $stable(valid_ff), "pipeline moved during output stall")
   `QTEL_ASSERT_HOLDS(a_pitch_range, clock, reset, !rsp_valid || (rsp_pitch_angle <= 14'sd6434 && rsp_pitch_angle >= -14'sd6434), "pitch out of range")
   `QTEL_ASSERT_HOLDS(a_roll_range, clock, reset, !rsp_valid || (rsp_roll_angle <= 15'sd12868 && rsp_roll_angle >= -15'sd12868), "roll out of range")

endmodule

`default_nettype wire
